/* rtl/cps_pkg.sv */
package cps_pkg;

	// coordinate and parameter formats
	localparam int COORD_W  = 16;
	localparam int PAR_FRAC = 16;

	// derived widths of the exact intermediate values
	localparam int DIF_W  = COORD_W + 1;
	localparam int PROD_W = 2 * DIF_W;
	localparam int LEN_W  = PROD_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int T_W    = PAR_FRAC + 1;
	localparam int TD_W   = T_W + 1 + DIF_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_A_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_A_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_B_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_B_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_B_Z = 3'd5;

	// parameter value of exactly one
	localparam logic [T_W-1:0] T_ONE = {1'b1, {PAR_FRAC{1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] closest_x;
		logic signed [COORD_W-1:0] closest_y;
		logic signed [COORD_W-1:0] closest_z;
	} result_t;

	// request into the divider pipeline
	typedef struct packed {
		logic                    valid;
		logic signed [DOT_W-1:0] dot;
		logic [LEN_W-1:0]        len;
	} div_req_t;

	// clamped projection parameter out of the divider pipeline
	typedef struct packed {
		logic           valid;
		logic [T_W-1:0] t;
	} div_rsp_t;

endpackage

/* rtl/closest_point_on_segment_unit.sv */
// Closest point on a 3D segment.
// The segment ends A and B are held in six configuration registers written
// over the cfg channel (index 0..2 = A x/y/z, 3..5 = B x/y/z, others ignored);
// cfg_ready is always high, and writes belong where no item is in flight, since
// later stages read the registers directly. The configuration registers reset to zero, so
// after reset every query returns the origin.
// A query point is taken on any clock edge with start high and busy low;
// busy stays low, so one item can enter every cycle.
// Each item gives exactly one result, shown on result for one cycle with
// done high. Results leave in order at the input rate: one item per cycle.
// The pipeline has three stages to form P-A, the products and
// the sums, a clamp stage plus sixteen one-bit divider stages for t, one
// multiply stage for t*D and the output register.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears all valid bits; items in flight are dropped.
module closest_point_on_segment_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  cps_pkg::point_t                   point,
	output logic                              done,
	output cps_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cps_pkg::COORD_W-1:0]       cfg_data
);
	import cps_pkg::*;

	logic signed [COORD_W-1:0] seg_a_q [0:2];
	logic signed [COORD_W-1:0] seg_b_q [0:2];
	logic signed [DIF_W-1:0]   dir_q   [0:2];
	logic signed [COORD_W-1:0] pt      [0:2];

	logic                      valid_s1;
	logic signed [DIF_W-1:0]   p_s1 [0:2];
	logic signed [DIF_W-1:0]   d_s1 [0:2];
	logic                      valid_s2;
	logic signed [PROD_W-1:0]  pd_s2 [0:2];
	logic signed [PROD_W-1:0]  dd_s2 [0:2];
	logic                      valid_s3;
	logic signed [DOT_W-1:0]   dot_s3;
	logic [LEN_W-1:0]          len_s3;
	logic                      valid_s4;
	logic signed [TD_W-1:0]    td_s4 [0:2];
	logic                      valid_s5;
	result_t                   result_s5;

	div_req_t                  dreq;
	div_rsp_t                  drsp;
	logic signed [COORD_W-1:0] res [0:2];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign pt[0] = point.point_x;
	assign pt[1] = point.point_y;
	assign pt[2] = point.point_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				seg_a_q[i] <= '0;
				seg_b_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SEG_A_X: seg_a_q[0] <= cfg_data;
				CFG_SEG_A_Y: seg_a_q[1] <= cfg_data;
				CFG_SEG_A_Z: seg_a_q[2] <= cfg_data;
				CFG_SEG_B_X: seg_b_q[0] <= cfg_data;
				CFG_SEG_B_Y: seg_b_q[1] <= cfg_data;
				CFG_SEG_B_Z: seg_b_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// segment direction for the back end, settles in the cycle after a write
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dir_q[i] <= DIF_W'(seg_b_q[i]) - DIF_W'(seg_a_q[i]);
		end
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= drsp.valid;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: offsets from the segment start
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= DIF_W'(pt[i]) - DIF_W'(seg_a_q[i]);
			d_s1[i] <= DIF_W'(seg_b_q[i]) - DIF_W'(seg_a_q[i]);
		end
	end

	// stage 2: per-axis products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pd_s2[i] <= p_s1[i] * d_s1[i];
			dd_s2[i] <= d_s1[i] * d_s1[i];
		end
	end

	// stage 3: dot product and squared length
	always_ff @(posedge clk) begin
		dot_s3 <= DOT_W'(pd_s2[0]) + DOT_W'(pd_s2[1]) + DOT_W'(pd_s2[2]);
		len_s3 <= LEN_W'($unsigned(dd_s2[0])) + LEN_W'($unsigned(dd_s2[1]))
			+ LEN_W'($unsigned(dd_s2[2]));
	end

	// clamp and divide
	assign dreq.valid = valid_s3;
	assign dreq.dot   = dot_s3;
	assign dreq.len   = len_s3;

	cps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// stage 4: scale the direction by t
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			td_s4[i] <= $signed({1'b0, drsp.t}) * dir_q[i];
		end
	end

	// floor shift and offset by the segment start
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = seg_a_q[i] + COORD_W'(td_s4[i] >>> PAR_FRAC);
		end
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		result_s5.closest_x <= res[0];
		result_s5.closest_y <= res[1];
		result_s5.closest_z <= res[2];
	end

	assign done   = valid_s5;
	assign result = result_s5;

endmodule

/* rtl/cps_div.sv */
module cps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cps_pkg::div_req_t req,
	output cps_pkg::div_rsp_t rsp
);
	import cps_pkg::*;

	typedef struct packed {
		logic [LEN_W-1:0]    rem;
		logic [LEN_W-1:0]    len;
		logic [PAR_FRAC-1:0] quo;
		logic                one;
	} div_stage_t;

	logic [PAR_FRAC:0] vld_s;
	div_stage_t        stg_s   [0:PAR_FRAC];
	div_stage_t        stg_nxt [1:PAR_FRAC];
	logic [LEN_W:0]    shifted [1:PAR_FRAC];
	logic [LEN_W:0]    diff    [1:PAR_FRAC];
	logic              at_full;
	logic              in_range;

	// clamp checks: at or past the end, or strictly inside
	assign at_full  = req.dot >= $signed({2'b00, req.len});
	assign in_range = (req.dot > $signed(DOT_W'(0))) && !at_full;

	// one quotient bit per stage, restoring
	always_comb begin
		for (int k = 1; k <= PAR_FRAC; k++) begin
			shifted[k] = {stg_s[k-1].rem, 1'b0};
			diff[k]    = shifted[k] - {1'b0, stg_s[k-1].len};
			stg_nxt[k].len = stg_s[k-1].len;
			stg_nxt[k].one = stg_s[k-1].one;
			if (shifted[k] >= {1'b0, stg_s[k-1].len}) begin
				stg_nxt[k].rem = diff[k][LEN_W-1:0];
				stg_nxt[k].quo = {stg_s[k-1].quo[PAR_FRAC-2:0], 1'b1};
			end else begin
				stg_nxt[k].rem = shifted[k][LEN_W-1:0];
				stg_nxt[k].quo = {stg_s[k-1].quo[PAR_FRAC-2:0], 1'b0};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[PAR_FRAC-1:0], req.valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		stg_s[0].rem <= in_range ? req.dot[LEN_W-1:0] : '0;
		stg_s[0].len <= req.len;
		stg_s[0].quo <= '0;
		stg_s[0].one <= at_full;
		for (int k = 1; k <= PAR_FRAC; k++) begin
			stg_s[k] <= stg_nxt[k];
		end
	end

	assign rsp.valid = vld_s[PAR_FRAC];
	assign rsp.t     = stg_s[PAR_FRAC].one ? T_ONE : {1'b0, stg_s[PAR_FRAC].quo};

endmodule
